// ===== src/hfd_pkg.sv =====
// Shared types and constants for the hex float to IEEE double converter.
package hfd_pkg;
    localparam int FracW = 56;
    localparam int PosW = 6;
    localparam int MantBits = 52;
    localparam logic [10:0] ExpOffset = 11'd711;

    typedef struct packed {
        logic             sign;
        logic [6:0]       chr;
        logic [PosW-1:0]  lz;
        logic [FracW-1:0] frac;
    } s1_t;

    typedef struct packed {
        logic            sign;
        logic            zero;
        logic [10:0]     bexp;
        logic [FracW-1:0] norm;
    } s2_t;
endpackage

// ===== src/hfd_if.sv =====
// Valid/ready channel carrying a 64-bit item.
interface hfd_if;
    logic        valid;
    logic        ready;
    logic [31:0] high_word;
    logic [31:0] low_word;
    logic [63:0] ieee_bits;
    modport source (output valid, input ready, output high_word, output low_word,
                    output ieee_bits);
    modport sink (input valid, output ready, input high_word, input low_word,
                  input ieee_bits);
endinterface

// ===== src/hfd_lzc.sv =====
// Leading zero count of the 56-bit fraction.
module hfd_lzc
(
    input  logic [hfd_pkg::FracW-1:0] frac,
    output logic [hfd_pkg::PosW-1:0]  lz
);
    always_comb
    begin
        lz = hfd_pkg::PosW'(hfd_pkg::FracW - 1);
        for (int i = 0; i < hfd_pkg::FracW; i++)
        begin
            if (frac[i])
            begin
                lz = hfd_pkg::PosW'(hfd_pkg::FracW - 1 - i);
            end
        end
    end
endmodule

// ===== src/hex_float_to_ieee_double.sv =====
// Top level: base-16 long float to IEEE 754 double converter.
// Each accepted input is registered in s1_reg, then s2_reg, then res_reg before output valid.
// Throughput: one item per cycle while the output is not stalled; the three register stages advance together.
// A stall holds all stages; nothing is lost or repeated.
// Reset clears the stage valid bits; payload registers are not reset.
module hex_float_to_ieee_double
(
    input logic clk,
    input logic rst_n,
    hfd_if.sink   in_ch,
    hfd_if.source out_ch
);
    logic v1_reg, v2_reg, v3_reg;
    hfd_pkg::s1_t s1_reg, s1_next;
    hfd_pkg::s2_t s2_reg, s2_next;
    logic [63:0] res_reg, res_next;
    logic adv;
    logic [hfd_pkg::FracW-1:0] frac_in;
    logic [hfd_pkg::PosW-1:0] lz;
    logic [52:0] sig;
    logic [53:0] sum;
    logic rnd;
    logic [10:0] e;

    assign adv = !v3_reg || out_ch.ready;
    assign in_ch.ready = adv;
    assign out_ch.valid = v3_reg;
    assign out_ch.ieee_bits = res_reg;
    assign out_ch.high_word = '0;
    assign out_ch.low_word = '0;

    assign frac_in = {in_ch.high_word[23:0], in_ch.low_word};

    hfd_lzc u_lzc (.frac(frac_in), .lz(lz));

    always_comb
    begin
        s1_next.sign = in_ch.high_word[31];
        s1_next.chr = in_ch.high_word[30:24];
        s1_next.lz = lz;
        s1_next.frac = frac_in;
    end

    always_comb
    begin
        s2_next.sign = s1_reg.sign;
        s2_next.zero = (s1_reg.frac == '0);
        s2_next.norm = s1_reg.frac << s1_reg.lz;
        s2_next.bexp = hfd_pkg::ExpOffset + 11'(hfd_pkg::FracW - 1) - 11'(s1_reg.lz)
                       + {2'b0, s1_reg.chr, 2'b0};
    end

    always_comb
    begin
        sig = s2_reg.norm[55:3];
        rnd = s2_reg.norm[2] && (s2_reg.norm[1] || s2_reg.norm[0] || sig[0]);
        sum = {1'b0, sig} + 54'(rnd);
        e = s2_reg.bexp + 11'(sum[53]);
        if (s2_reg.zero)
        begin
            res_next = {s2_reg.sign, 63'b0};
        end
        else
        begin
            res_next = {s2_reg.sign, e, sum[53] ? 52'b0 : sum[51:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_ch.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            res_reg <= res_next;
        end
    end
endmodule

// ===== src/hfd_checker.sv =====
// Port-level checks for the converter, bound to the top level.
module hfd_checker
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic [63:0] ieee_bits
);
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready) else $error("input stalled with empty output");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(ieee_bits))
        else $error("stalled result changed");
    a_norm: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ieee_bits[62:0] != 63'b0 |-> ieee_bits[62:52] >= 11'd711)
        else $error("exponent out of range");
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready ##1 out_ready [*2] |=> out_valid)
        else $error("result missing");
endmodule

bind hex_float_to_ieee_double hfd_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .ieee_bits(out_ch.ieee_bits));

// ===== tb/sv/hex_float_to_ieee_double_tb.sv =====
// Testbench for the hex float to IEEE double converter: directed table, then random items.
`timescale 1ns / 1ps
module hex_float_to_ieee_double_tb;
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    hfd_if in_ch ();
    hfd_if out_ch ();

    hex_float_to_ieee_double dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    always #5 clk = ~clk;

    typedef struct {
        logic [31:0] hi;
        logic [31:0] lo;
        logic        known;
        logic [63:0] bits;
    } hex_row_t;

    logic [63:0] pending_bits[$];
    int          mismatch_count = 0;
    int          items_sent = 0;
    int          results_seen = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_off_cycles = 0;
    bit          hold_start = 1'b0;
    bit          stim_done = 1'b0;

    function automatic logic [63:0] hex_to_double(logic [31:0] hi, logic [31:0] lo);
        logic [55:0] frac;
        logic [55:0] remd;
        logic [55:0] half;
        logic [55:0] sig;
        logic [11:0] bexp;
        int          top;
        int          sh;
        frac = {hi[23:0], lo};
        if (frac == 56'd0)
            return {hi[31], 63'd0};
        top = 0;
        for (int i = 0; i < 56; i++)
            if (frac[i])
                top = i;
        bexp = 12'(top) + 12'(4 * hi[30:24]) + 12'd711;
        if (top <= 52)
        begin
            sig = frac << (52 - top);
        end
        else
        begin
            sh = top - 52;
            remd = frac & ((56'd1 << sh) - 56'd1);
            half = 56'd1 << (sh - 1);
            sig = frac >> sh;
            if (remd > half || (remd == half && sig[0]))
                sig = sig + 56'd1;
            if (sig == (56'd1 << 53))
            begin
                sig = sig >> 1;
                bexp = bexp + 12'd1;
            end
        end
        return {hi[31], bexp[10:0], sig[51:0]};
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        mismatch_count++;
        $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
    endtask

    task automatic send_item(logic [31:0] hi, logic [31:0] lo);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.high_word <= hi;
        in_ch.low_word <= lo;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        pending_bits.push_back(hex_to_double(hi, lo));
        items_sent++;
        @(negedge clk);
    endtask

    initial
    begin
        wait (hold_start);
        @(negedge clk);
        hold_off_cycles = 60;
        while (hold_off_cycles > 0)
        begin
            @(negedge clk);
            hold_off_cycles = hold_off_cycles - 1;
        end
    end

    always @(negedge clk)
    begin
        if (hold_off_cycles > 0)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            results_seen++;
            if (pending_bits.size() == 0)
                report_mismatch("unexpected item", out_ch.ieee_bits, 64'd0);
            else if (out_ch.ieee_bits !== pending_bits[0])
                report_mismatch("ieee_bits", out_ch.ieee_bits, pending_bits.pop_front());
            else
                void'(pending_bits.pop_front());
        end
    end

    hex_row_t directed_rows[] = '{
        '{32'h0000_0000, 32'h0000_0000, 1'b1, 64'h0000_0000_0000_0000},
        '{32'h8000_0000, 32'h0000_0000, 1'b1, 64'h8000_0000_0000_0000},
        '{32'h7F00_0000, 32'h0000_0000, 1'b1, 64'h0000_0000_0000_0000},
        '{32'hFF00_0000, 32'h0000_0000, 1'b1, 64'h8000_0000_0000_0000},
        '{32'h4110_0000, 32'h0000_0000, 1'b1, 64'h3FF0_0000_0000_0000},
        '{32'hC110_0000, 32'h0000_0000, 1'b1, 64'hBFF0_0000_0000_0000},
        '{32'h0000_0000, 32'h0000_0001, 1'b1, 64'h2C70_0000_0000_0000},
        '{32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0, 64'd0},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 64'd0},
        '{32'h0080_0000, 32'h0000_0000, 1'b0, 64'd0},
        '{32'h4100_0000, 32'h0000_0001, 1'b0, 64'd0},
        '{32'h40FF_FFFF, 32'hFFFF_FFF8, 1'b0, 64'd0},
        '{32'h40FF_FFFF, 32'hFFFF_FFF7, 1'b0, 64'd0},
        '{32'h4080_0000, 32'h0000_0008, 1'b0, 64'd0},
        '{32'h4080_0000, 32'h0000_0018, 1'b0, 64'd0},
        '{32'h4080_0000, 32'h0000_0009, 1'b0, 64'd0},
        '{32'h4010_0000, 32'h0000_0001, 1'b0, 64'd0},
        '{32'h2AAA_AAAA, 32'h5555_5555, 1'b0, 64'd0},
        '{32'hD555_5555, 32'hAAAA_AAAA, 1'b0, 64'd0}
    };

    task automatic random_item();
        logic [31:0] hi;
        logic [31:0] lo;
        int          width;
        hi = $urandom();
        lo = $urandom();
        case ($urandom_range(3))
            0:
            begin
                width = $urandom_range(56, 1);
                {hi[23:0], lo} = {hi[23:0], lo} & ((56'd1 << width) - 56'd1);
            end
            1:
            begin
                lo[7:0] = $urandom_range(1) ? 8'h80 : 8'h7F;
                if ($urandom_range(1))
                    {hi[23:0], lo[31:8]} = '1;
            end
            default:
            begin
            end
        endcase
        send_item(hi, lo);
    endtask

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.high_word = '0;
        in_ch.low_word = '0;
        in_ch.ieee_bits = '0;
        out_ch.ready = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        send_idle_pct = 9;
        recv_idle_pct = 52;
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].known
                && hex_to_double(directed_rows[i].hi, directed_rows[i].lo)
                   !== directed_rows[i].bits)
                report_mismatch("table", hex_to_double(directed_rows[i].hi,
                    directed_rows[i].lo), directed_rows[i].bits);
            send_item(directed_rows[i].hi, directed_rows[i].lo);
        end
        hold_start = 1'b1;
        repeat (40) random_item();
        repeat (320) random_item();
        send_idle_pct = 52;
        recv_idle_pct = 9;
        repeat (360) random_item();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (380) random_item();
        in_ch.valid <= 1'b0;
        stim_done = 1'b1;
        while (pending_bits.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        $display("Converted %0d items (%0d results checked), %0d mismatches.",
                 items_sent, results_seen, mismatch_count);
        $display("Covered zeros, extremes, rounding ties and carries, stalls and backpressure.");
        if (mismatch_count == 0 && pending_bits.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("Timeout with %0d items outstanding", pending_bits.size());
        $display("*** FAILED ***");
        $finish;
    end
endmodule

// ===== files.f =====
src/hfd_pkg.sv
src/hfd_if.sv
src/hfd_lzc.sv
src/hex_float_to_ieee_double.sv
src/hfd_checker.sv
tb/sv/hex_float_to_ieee_double_tb.sv
